// File: rtl/afd_pkg.sv
// Package for the ADC frame deserializer: word kinds, format codes,
// register indexes, CRC constants, shared structs and the byte-wide CRC update.
// Used by every module of the block; depends on nothing.
package afd_pkg;

    localparam int MAX_CHANNELS = 8;

    localparam logic [3:0]  FRAME_ENDED = 4'hF;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] POLY_CCITT  = 16'h1021;
    localparam logic [15:0] POLY_ANSI   = 16'h8005;

    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_FORMAT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS_IN_USE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_KIND        = 2'd2;

    typedef enum logic [1:0] {
        FMT_16_TRUNC = 2'd0,
        FMT_24       = 2'd1,
        FMT_32_ZPAD  = 2'd2,
        FMT_32_SEXT  = 2'd3
    } afd_format_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_CRC    = 2'd2
    } afd_word_kind_t;

    typedef struct packed {
        afd_format_t word_format;
        logic [3:0]  channels_in_use;
        logic        crc_kind;
    } afd_cfg_t;

    typedef struct packed {
        logic [1:0]         word_kind;
        logic [2:0]         channel_index;
        logic signed [31:0] word_value;
        logic [15:0]        computed_crc;
        logic               crc_ok;
        logic               frame_last;
    } afd_result_t;

    // bytes per word for each format code
    function automatic logic [2:0] word_length(input afd_format_t fmt);
        logic [2:0] len;
        case (fmt)
            FMT_16_TRUNC: len = 3'd2;
            FMT_24:       len = 3'd3;
            FMT_32_ZPAD:  len = 3'd4;
            FMT_32_SEXT:  len = 3'd4;
            default:      len = 3'd4;
        endcase
        return len;
    endfunction

    // MSB-first CRC-16 over one byte, no reflection
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] crc;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            if (data[i] ^ crc[15])
                crc = {crc[14:0], 1'b0} ^ poly;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// File: rtl/afd_in_if.sv
// Byte input channel of the ADC frame deserializer: valid/ready plus payload.
// Depends on nothing.
interface afd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source(output valid, output rx_byte, output frame_start, input ready);
    modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

// File: rtl/afd_out_if.sv
// Result channel of the ADC frame deserializer: valid/ready plus decoded word.
// Depends on nothing.
interface afd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         word_kind;
    logic [2:0]         channel_index;
    logic signed [31:0] word_value;
    logic [15:0]        computed_crc;
    logic               crc_ok;
    logic               frame_last;

    modport source(output valid, output word_kind, output channel_index,
                   output word_value, output computed_crc, output crc_ok,
                   output frame_last, input ready);
    modport sink(input valid, input word_kind, input channel_index,
                 input word_value, input computed_crc, input crc_ok,
                 input frame_last, output ready);
endinterface

// File: rtl/afd_frame_core.sv
// Frame tracking core: byte/word counters, word assembly, running CRC and
// per-word decode, one byte per transfer. Depends on afd_pkg.
module afd_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  afd_pkg::afd_cfg_t cfg,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    output logic              result_valid,
    output afd_pkg::afd_result_t result
);

    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [3:0]  word_pos_reg, word_pos_next;
    logic [31:0] word_bytes_reg, word_bytes_next;
    logic [15:0] crc_reg, crc_next;

    logic [1:0]  bp0;
    logic [3:0]  wp0;
    logic [31:0] wb0, wb1, w;
    logic [15:0] crc0, crc1, head;
    logic [2:0]  len;
    logic [3:0]  ch;
    logic        is_crc, done, ended;
    logic [3:0]  wp_minus1;
    logic signed [31:0] sample;

    always_comb
    begin
        // frame start restarts everything before the byte is taken
        bp0  = frame_start ? 2'd0 : byte_pos_reg;
        wp0  = frame_start ? 4'd0 : word_pos_reg;
        wb0  = frame_start ? 32'd0 : word_bytes_reg;
        crc0 = frame_start ? afd_pkg::CRC_INIT : crc_reg;

        ended = (wp0 == afd_pkg::FRAME_ENDED);
        len   = afd_pkg::word_length(cfg.word_format);

        if (cfg.channels_in_use == 4'd0)
            ch = 4'd1;
        else if (cfg.channels_in_use > 4'(afd_pkg::MAX_CHANNELS))
            ch = 4'(afd_pkg::MAX_CHANNELS);
        else
            ch = cfg.channels_in_use;
        is_crc = (wp0 > ch);

        wb1  = {wb0[23:0], rx_byte};
        crc1 = is_crc ? crc0
             : afd_pkg::crc_byte(crc0, rx_byte,
                                 cfg.crc_kind ? afd_pkg::POLY_ANSI : afd_pkg::POLY_CCITT);
        done = !(({1'b0, bp0} + 3'd1) < len);

        case (len)
            3'd2:    w = {16'd0, wb1[15:0]};
            3'd3:    w = {8'd0, wb1[23:0]};
            default: w = wb1;
        endcase
        case (len)
            3'd2:    head = w[15:0];
            3'd3:    head = w[23:8];
            default: head = w[31:16];
        endcase

        case (cfg.word_format)
            afd_pkg::FMT_16_TRUNC: sample = {{16{w[15]}}, w[15:0]};
            afd_pkg::FMT_24:       sample = {{8{w[23]}}, w[23:0]};
            afd_pkg::FMT_32_ZPAD:  sample = {{8{w[31]}}, w[31:8]};
            default:               sample = w;
        endcase

        wp_minus1 = wp0 - 4'd1;
    end

    always_comb
    begin
        result.channel_index = 3'd0;
        result.word_value    = {16'd0, head};
        result.computed_crc  = crc1;
        result.crc_ok        = 1'b0;
        result.frame_last    = 1'b0;
        if (wp0 == 4'd0) begin
            result.word_kind = afd_pkg::KIND_STATUS;
        end
        else if (!is_crc) begin
            result.word_kind     = afd_pkg::KIND_SAMPLE;
            result.channel_index = wp_minus1[2:0];
            result.word_value    = sample;
        end
        else begin
            result.word_kind  = afd_pkg::KIND_CRC;
            result.crc_ok     = (head == crc1);
            result.frame_last = 1'b1;
        end
        result_valid = accept && !ended && done;
    end

    always_comb
    begin
        byte_pos_next   = bp0;
        word_pos_next   = wp0;
        word_bytes_next = wb0;
        crc_next        = crc0;
        if (!ended) begin
            crc_next = crc1;
            if (!done) begin
                byte_pos_next   = bp0 + 2'd1;
                word_bytes_next = wb1;
            end
            else begin
                byte_pos_next   = 2'd0;
                word_bytes_next = 32'd0;
                word_pos_next   = is_crc ? afd_pkg::FRAME_ENDED : wp0 + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_pos_reg   <= 2'd0;
            word_pos_reg   <= 4'd0;
            word_bytes_reg <= 32'd0;
            crc_reg        <= afd_pkg::CRC_INIT;
        end
        else if (accept) begin
            byte_pos_reg   <= byte_pos_next;
            word_pos_reg   <= word_pos_next;
            word_bytes_reg <= word_bytes_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

// File: rtl/afd_result_buf.sv
// Two-entry result buffer, a circular queue with read and write pointers, so a byte
// can be taken while a finished word waits downstream. Depends on afd_pkg, afd_out_if.
module afd_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  afd_pkg::afd_result_t push_data,
    output logic                 has_room,
    afd_out_if.source            result
);

    afd_pkg::afd_result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign has_room = (count_reg != 2'd2);
    assign pop      = result.valid && result.ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_comb
    begin
        result.valid         = (count_reg != 2'd0);
        result.word_kind     = entry_reg[rd_ptr_reg].word_kind;
        result.channel_index = entry_reg[rd_ptr_reg].channel_index;
        result.word_value    = entry_reg[rd_ptr_reg].word_value;
        result.computed_crc  = entry_reg[rd_ptr_reg].computed_crc;
        result.crc_ok        = entry_reg[rd_ptr_reg].crc_ok;
        result.frame_last    = entry_reg[rd_ptr_reg].frame_last;
    end

endmodule

// File: rtl/adc_frame_deserializer.sv
// ADC frame deserializer top level: configuration registers, frame core and
// result buffer. Depends on afd_pkg, afd_in_if, afd_out_if and the submodules.
//
// Takes one frame byte per clock while input ready is high (ready drops only
// when both result buffer entries are full) and emits one result per completed
// word (status, channel sample, received CRC), written into the result buffer
// as the word's last byte is transferred in. Word assembly and the byte-wide
// CRC-16 update are combinational; the two-entry buffer keeps bytes flowing
// while a result waits. Configuration writes take effect from the next byte.
module adc_frame_deserializer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [afd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]    cfg_data,
    afd_in_if.sink                            rx,
    afd_out_if.source                         result
);

    afd_pkg::afd_cfg_t    cfg_reg;
    afd_pkg::afd_result_t core_result;
    logic                 core_valid;
    logic                 has_room;
    logic                 accept;

    assign rx.ready = has_room;
    assign accept   = rx.valid && has_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.word_format     <= afd_pkg::FMT_24;
            cfg_reg.channels_in_use <= 4'd8;
            cfg_reg.crc_kind        <= 1'b0;
        end
        else if (cfg_write) begin
            case (cfg_index)
                afd_pkg::CFG_WORD_FORMAT:
                    cfg_reg.word_format <= afd_pkg::afd_format_t'(cfg_data[1:0]);
                afd_pkg::CFG_CHANNELS_IN_USE:
                    cfg_reg.channels_in_use <= cfg_data[3:0];
                afd_pkg::CFG_CRC_KIND:
                    cfg_reg.crc_kind <= cfg_data[0];
                default: ;
            endcase
        end
    end

    afd_frame_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .rx_byte      (rx.rx_byte),
        .frame_start  (rx.frame_start),
        .result_valid (core_valid),
        .result       (core_result)
    );

    afd_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_valid),
        .push_data (core_result),
        .has_room  (has_room),
        .result    (result)
    );

endmodule
